[design/rgba_point_filter_chain_defines.svh]
// Assertion macros for the checker of the RGBA point filter chain.
`ifndef RGBA_POINT_FILTER_CHAIN_DEFINES_SVH
`define RGBA_POINT_FILTER_CHAIN_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RPF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define RPF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define RPF_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[design/rpf_pkg.sv]
// Types, constants and point functions shared by the RGBA point filter chain.
package rpf_pkg;

    localparam logic [7:0] CelTop = 8'd255;
    localparam logic [7:0] CelL4  = 8'd213;
    localparam logic [7:0] CelL3  = 8'd171;
    localparam logic [7:0] CelL2  = 8'd129;
    localparam logic [7:0] CelL1  = 8'd87;
    localparam logic [7:0] CelL0  = 8'd45;
    localparam logic [7:0] ChanMax = 8'd255;

    // floor(s / 3) equals (s * 683) >> 11 for every sum s of three bytes.
    localparam logic [19:0] GrayRecip = 20'd683;
    localparam int GrayShift = 11;

    typedef enum logic [2:0] {
        REG_GRAY_EN      = 3'd0,
        REG_THRESH_EN    = 3'd1,
        REG_THRESH_LEVEL = 3'd2,
        REG_INVERT_EN    = 3'd3,
        REG_MASK_EN      = 3'd4,
        REG_POSTER_EN    = 3'd5,
        REG_POST_GRAY_EN = 3'd6
    } cfg_reg_t;

    // Color lanes: index 0 red, 1 green, 2 blue.
    typedef struct packed {
        logic            last;
        logic [7:0]      alpha;
        logic [2:0][7:0] color;
        logic [2:0][7:0] orig;
    } pix_t;

    function automatic logic [7:0] mean3(input logic [2:0][7:0] c);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = {2'b00, c[0]} + {2'b00, c[1]} + {2'b00, c[2]};
        prod = 20'(sum) * GrayRecip;
        return prod[GrayShift +: 8];
    endfunction

    function automatic logic [7:0] cel_level(input logic [7:0] v);
        logic [7:0] lvl;
        if (v > CelL4) begin
            lvl = CelTop;
        end else if (v > CelL3) begin
            lvl = CelL4;
        end else if (v > CelL2) begin
            lvl = CelL3;
        end else if (v > CelL1) begin
            lvl = CelL2;
        end else if (v > CelL0) begin
            lvl = CelL1;
        end else begin
            lvl = CelL0;
        end
        return lvl;
    endfunction

    function automatic logic [7:0] norm_alpha(input logic [7:0] a);
        return (a != 8'd0) ? ChanMax : 8'd0;
    endfunction

endpackage

[design/rpf_gray_stage.sv]
// Pipeline stage that optionally replaces the color with its gray mean.
module rpf_gray_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpf_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output rpf_pkg::pix_t out_pix
);
    import rpf_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    pix_t       pix_reg;
    pix_t       pix_next;
    logic [7:0] gray;

    always_comb begin
        gray     = mean3(in_pix.color);
        pix_next = in_pix;
        if (en) begin
            pix_next.color = {gray, gray, gray};
            pix_next.alpha = norm_alpha(in_pix.alpha);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

[design/rpf_thresh_stage.sv]
// Pipeline stage that optionally sets the color to black or white by its mean.
module rpf_thresh_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [7:0]    level,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpf_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output rpf_pkg::pix_t out_pix
);
    import rpf_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    pix_t       pix_reg;
    pix_t       pix_next;
    logic [7:0] bw;

    always_comb begin
        bw       = (mean3(in_pix.color) > level) ? ChanMax : 8'd0;
        pix_next = in_pix;
        if (en) begin
            pix_next.color = {bw, bw, bw};
            pix_next.alpha = norm_alpha(in_pix.alpha);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

[design/rpf_invmask_stage.sv]
// Pipeline stage that optionally inverts the color and then uses it as a mask on the original input color.
module rpf_invmask_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          inv_en,
    input  logic          mask_en,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpf_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output rpf_pkg::pix_t out_pix
);
    import rpf_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    pix_t            pix_reg;
    pix_t            pix_next;
    logic [2:0][7:0] inv_color;
    logic [7:0]      alpha_inv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            inv_color[k] = inv_en ? (ChanMax - in_pix.color[k]) : in_pix.color[k];
        end
        alpha_inv = inv_en ? norm_alpha(in_pix.alpha) : in_pix.alpha;
        pix_next       = in_pix;
        pix_next.color = inv_color;
        pix_next.alpha = alpha_inv;
        if (mask_en) begin
            for (int k = 0; k < 3; k++) begin
                pix_next.color[k] = (inv_color[k] != 8'd0) ? in_pix.orig[k] : 8'd0;
            end
            pix_next.alpha = norm_alpha(alpha_inv);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

[design/rpf_poster_stage.sv]
// Pipeline stage that optionally quantizes each color channel to six levels.
module rpf_poster_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpf_pkg::pix_t in_pix,
    output logic          out_valid,
    input  logic          out_ready,
    output rpf_pkg::pix_t out_pix
);
    import rpf_pkg::*;

    logic valid_reg;
    logic valid_next;
    pix_t pix_reg;
    pix_t pix_next;

    always_comb begin
        pix_next = in_pix;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pix_next.color[k] = cel_level(in_pix.color[k]);
            end
            pix_next.alpha = norm_alpha(in_pix.alpha);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

[design/rgba_point_filter_chain.sv]
// Top level of the RGBA point filter chain: five registered point stages on a pixel stream.
//
// The block takes one RGBA pixel per beat and returns one processed pixel per beat, in
// order, with the last flag copied through. It sustains one pixel per clock while m_tready
// is high and has one register stage for each of gray, threshold, invert with mask,
// posterize and the final gray; the stages read the enables directly, and each
// stage that is enabled squares alpha off to 0 or 255. Every stage holds its beat while
// the stage after it is full and stalled, and an empty stage takes a new beat even while
// later stages wait, so a stall on the result side loses and repeats nothing. The
// s_tready path runs combinationally from m_tready back through the five stages. The
// configuration port takes a write in every cycle (cfg_ready is always high); register
// indexes are 0 gray enable, 1 threshold enable, 2 threshold level, 3 invert enable,
// 4 mask enable, 5 posterize enable, 6 final gray enable, and index 7 is ignored. Write
// the registers only while no pixel is in flight.
module rgba_point_filter_chain (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_red, in_green, in_blue, in_alpha from bit 0 up
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha from bit 0 up
    output logic        m_tlast,   // out_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import rpf_pkg::*;

    logic       gray_en_reg;
    logic       thresh_en_reg;
    logic [7:0] thresh_level_reg;
    logic       invert_en_reg;
    logic       mask_en_reg;
    logic       poster_en_reg;
    logic       post_gray_en_reg;

    pix_t in_pix;
    pix_t gray_pix;
    pix_t thresh_pix;
    pix_t invmask_pix;
    pix_t poster_pix;
    pix_t out_pix;

    logic gray_valid;
    logic gray_ready;
    logic thresh_valid;
    logic thresh_ready;
    logic invmask_valid;
    logic invmask_ready;
    logic poster_valid;
    logic poster_ready;

    // Configuration registers; each write goes straight into its register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_en_reg      <= 1'b0;
            thresh_en_reg    <= 1'b0;
            thresh_level_reg <= 8'd0;
            invert_en_reg    <= 1'b0;
            mask_en_reg      <= 1'b0;
            poster_en_reg    <= 1'b0;
            post_gray_en_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_GRAY_EN:      gray_en_reg      <= cfg_data[0];
                REG_THRESH_EN:    thresh_en_reg    <= cfg_data[0];
                REG_THRESH_LEVEL: thresh_level_reg <= cfg_data;
                REG_INVERT_EN:    invert_en_reg    <= cfg_data[0];
                REG_MASK_EN:      mask_en_reg      <= cfg_data[0];
                REG_POSTER_EN:    poster_en_reg    <= cfg_data[0];
                REG_POST_GRAY_EN: post_gray_en_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the input beat; the original color rides along for the mask stage.
    always_comb begin
        in_pix.last     = s_tlast;
        in_pix.alpha    = s_tdata[31:24];
        in_pix.color[0] = s_tdata[7:0];
        in_pix.color[1] = s_tdata[15:8];
        in_pix.color[2] = s_tdata[23:16];
        in_pix.orig     = in_pix.color;
    end

    rpf_gray_stage u_gray (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (gray_en_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (in_pix),
        .out_valid (gray_valid),
        .out_ready (gray_ready),
        .out_pix   (gray_pix)
    );

    rpf_thresh_stage u_thresh (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (thresh_en_reg),
        .level     (thresh_level_reg),
        .in_valid  (gray_valid),
        .in_ready  (gray_ready),
        .in_pix    (gray_pix),
        .out_valid (thresh_valid),
        .out_ready (thresh_ready),
        .out_pix   (thresh_pix)
    );

    rpf_invmask_stage u_invmask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .inv_en    (invert_en_reg),
        .mask_en   (mask_en_reg),
        .in_valid  (thresh_valid),
        .in_ready  (thresh_ready),
        .in_pix    (thresh_pix),
        .out_valid (invmask_valid),
        .out_ready (invmask_ready),
        .out_pix   (invmask_pix)
    );

    rpf_poster_stage u_poster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (poster_en_reg),
        .in_valid  (invmask_valid),
        .in_ready  (invmask_ready),
        .in_pix    (invmask_pix),
        .out_valid (poster_valid),
        .out_ready (poster_ready),
        .out_pix   (poster_pix)
    );

    // The final gray stage is a second instance of the gray stage module; its register is the output register.
    rpf_gray_stage u_post_gray (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (post_gray_en_reg),
        .in_valid  (poster_valid),
        .in_ready  (poster_ready),
        .in_pix    (poster_pix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

    assign m_tdata = {out_pix.alpha, out_pix.color[2], out_pix.color[1], out_pix.color[0]};
    assign m_tlast = out_pix.last;

endmodule

[design/rgba_point_filter_chain_checker.sv]
// Port-level checker for the RGBA point filter chain, bound to the top level.
`include "rgba_point_filter_chain_defines.svh"

module rgba_point_filter_chain_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result beat keeps its payload.
    `RPF_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")

    // When the output register can move, the whole chain can take a beat.
    `RPF_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input stalled while output side free")

    // Reset empties the pipeline.
    `RPF_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid right after reset")

    // With five stages nothing reaches the output right after reset is released.
    `RPF_ASSERT_ALWAYS(a_reset_latency, aclk, !aresetn ##1 aresetn, !m_tvalid, "result arrived too early after reset")

endmodule

bind rgba_point_filter_chain rgba_point_filter_chain_checker u_checker (.*);
